FILE: hw/rtl/emi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emi_pkg: shared types and constants for the Euclidean modulo unit
// Port field width, default operand width, and the control word that rides
// along the divider pipeline.
// ----------------------------------------------------------------------------
package emi_pkg;

	// width of the operand and remainder ports
	localparam int FIELD_W = 64;

	// default operand width used inside the unit
	localparam int DATA_WIDTH_DEF = 64;

	// control word carried beside the data at every stage
	typedef struct packed {
		logic valid;  // stage holds a live word
		logic neg;    // signed mode, dividend negative
		logic zero;   // divisor was zero
	} ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/emi_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emi_prep: operand conditioning stage
// Masks operands to W bits, takes magnitudes in signed mode, flags a zero
// divisor, and registers the result for the cell chain.
// ----------------------------------------------------------------------------
module emi_prep #(
	parameter int W = emi_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  func,
	input  wire logic [W-1:0]          a,
	input  wire logic [W-1:0]          b,
	output emi_pkg::ctl_t              ctl_s1,
	output logic [W-1:0]               a_s1,
	output logic [W-1:0]               b_s1
);

	logic          is_signed;
	logic          a_neg;
	logic          b_neg;
	logic [W-1:0]  ma;
	logic [W-1:0]  mb;

	always_comb begin
		is_signed = ~func;
		a_neg     = is_signed & a[W-1];
		b_neg     = is_signed & b[W-1];
		ma        = a_neg ? (~a + 1'b1) : a;
		mb        = b_neg ? (~b + 1'b1) : b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.neg   <= a_neg;
			ctl_s1.zero  <= (b == '0);
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		a_s1 <= ma;
		b_s1 <= mb;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/emi_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emi_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits, and registers everything for the next cell.
// ----------------------------------------------------------------------------
module emi_cell #(
	parameter int W = emi_pkg::DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire emi_pkg::ctl_t ctl_i,
	input  wire logic [W-1:0]  r_i,
	input  wire logic [W-1:0]  a_i,
	input  wire logic [W-1:0]  b_i,
	output emi_pkg::ctl_t      ctl_q,
	output logic [W-1:0]       r_q,
	output logic [W-1:0]       a_q,
	output logic [W-1:0]       b_q
);

	logic [W:0]    rr;
	logic [W:0]    diff;
	logic [W-1:0]  r_nxt;

	always_comb begin
		rr    = {r_i, a_i[W-1]};
		diff  = rr - {1'b0, b_i};
		// borrow out means the divisor did not fit
		r_nxt = diff[W] ? rr[W-1:0] : diff[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		r_q <= r_nxt;
		a_q <= {a_i[W-2:0], 1'b0};
		b_q <= b_i;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/emi_fix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emi_fix: sign correction and output register
// Folds a nonzero remainder of a negative dividend to |b| - r, forces zero
// on a zero divisor, and drives the result strobe.
// ----------------------------------------------------------------------------
module emi_fix #(
	parameter int W = emi_pkg::DATA_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire emi_pkg::ctl_t ctl_i,
	input  wire logic [W-1:0]  r_i,
	input  wire logic [W-1:0]  b_i,
	output logic               done_q,
	output logic [W-1:0]       rem_q,
	output logic               zero_q
);

	logic [W-1:0] rem_nxt;

	always_comb begin
		if (ctl_i.zero) begin
			rem_nxt = '0;
		end else if (ctl_i.neg && (r_i != '0)) begin
			rem_nxt = b_i - r_i;
		end else begin
			rem_nxt = r_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_nxt;
		zero_q <= ctl_i.zero;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/euclidean_modulo_int64.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_modulo_int64: pipelined Euclidean / unsigned modulo unit
// Non-negative remainder of dividend by divisor, signed or unsigned, with a
// zero-divisor flag. A chain of restoring division cells, one per bit.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   command  | in        | start, busy        | func, dividend, divisor
//   result   | out       | done (one cycle)   | remainder, zero_divisor
//
// - One word accepted per cycle; busy is never raised.
// - The pipeline holds one conditioning stage, DATA_WIDTH division cells
//   (one quotient bit each), and one correction stage.
// - Throughput is set by the cell chain: every cell registers its step and
//   hands it on, so a new word enters each cycle.
// - arst_n clears every valid flag; words in flight are dropped.
// - The receiver cannot stall: done is high for exactly one cycle per word.
// ----------------------------------------------------------------------------
module euclidean_modulo_int64 #(
	parameter int DATA_WIDTH = emi_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         func,
	input  wire logic [emi_pkg::FIELD_W-1:0]  dividend,
	input  wire logic [emi_pkg::FIELD_W-1:0]  divisor,
	output logic                              done,
	output logic [emi_pkg::FIELD_W-1:0]       remainder,
	output logic                              zero_divisor
);

	localparam int W   = DATA_WIDTH;
	localparam int FW  = emi_pkg::FIELD_W;
	localparam int LAT = W + 2;

	// the chain never blocks
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	// links between stages: index 0 is the conditioning stage output,
	// index k+1 the output of cell k
	emi_pkg::ctl_t ctl_c [W+1];
	logic [W-1:0]  r_c   [W+1];
	logic [W-1:0]  a_c   [W+1];
	logic [W-1:0]  b_c   [W+1];

	emi_prep #(.W(W)) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.func   (func),
		.a      (dividend[W-1:0]),
		.b      (divisor[W-1:0]),
		.ctl_s1 (ctl_c[0]),
		.a_s1   (a_c[0]),
		.b_s1   (b_c[0])
	);

	// partial remainder starts empty
	assign r_c[0] = '0;

	// one cell per dividend bit, MSB first
	for (genvar k = 0; k < W; k++) begin : g_cell
		emi_cell #(.W(W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[k]),
			.r_i    (r_c[k]),
			.a_i    (a_c[k]),
			.b_i    (b_c[k]),
			.ctl_q  (ctl_c[k+1]),
			.r_q    (r_c[k+1]),
			.a_q    (a_c[k+1]),
			.b_q    (b_c[k+1])
		);
	end

	logic [W-1:0] rem_q;

	// last cell's remainder is |a| mod |b|; fix-up gives the Euclidean value
	emi_fix #(.W(W)) u_fix (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_c[W]),
		.r_i    (r_c[W]),
		.b_i    (b_c[W]),
		.done_q (done),
		.rem_q  (rem_q),
		.zero_q (zero_divisor)
	);

	// zero-extend to the port width
	assign remainder = FW'(rem_q);

	// a result only appears for an earlier accepted word
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching command");

	// a zero divisor flag belongs to a zero divisor and gives a zero result
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_divisor) |-> (($past(divisor[W-1:0], LAT) == '0)
		&& (remainder == '0)))
		else $error("zero divisor flag mismatch");

	// unsigned remainder stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !zero_divisor && $past(func, LAT))
		|-> (rem_q < $past(divisor[W-1:0], LAT)))
		else $error("unsigned remainder out of range");

endmodule
`default_nettype wire

FILE: bench/euclidean_modulo_int64_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_modulo_int64_check: remainder predictor and result checker
// Watches the command and result channels, works out the expected remainder
// and zero-divisor flag of every accepted word, and compares each result word
// in order against the oldest one outstanding.
// ----------------------------------------------------------------------------
module euclidean_modulo_int64_check #(
	parameter int DATA_WIDTH = emi_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic                        func,
	input  wire logic [emi_pkg::FIELD_W-1:0] dividend,
	input  wire logic [emi_pkg::FIELD_W-1:0] divisor,
	input  wire logic                        done,
	input  wire logic [emi_pkg::FIELD_W-1:0] remainder,
	input  wire logic                        zero_divisor,
	output int                               errors,
	output int                               pending,
	output int                               checked
);

	typedef struct packed {
		logic [emi_pkg::FIELD_W-1:0] remainder;
		logic                        zero_divisor;
	} mod_word_t;

	localparam logic [emi_pkg::FIELD_W-1:0] OPERAND_MASK =
		{emi_pkg::FIELD_W{1'b1}} >> (emi_pkg::FIELD_W - DATA_WIDTH);

	mod_word_t expected_words[$];
	mod_word_t oldest;
	int        bad;

	// two's complement magnitude at DATA_WIDTH bits
	function automatic logic [emi_pkg::FIELD_W-1:0] abs_value(
		input logic [emi_pkg::FIELD_W-1:0] v
	);
		if (v[DATA_WIDTH-1])
			return (~v + 1'b1) & OPERAND_MASK;
		return v;
	endfunction

	function automatic mod_word_t euclid_remainder(
		input logic                        is_unsigned,
		input logic [emi_pkg::FIELD_W-1:0] num_in,
		input logic [emi_pkg::FIELD_W-1:0] den_in
	);
		logic [emi_pkg::FIELD_W-1:0] num;
		logic [emi_pkg::FIELD_W-1:0] den;
		logic [emi_pkg::FIELD_W-1:0] den_mag;
		logic [emi_pkg::FIELD_W-1:0] trunc;
		mod_word_t                   w;
		num = num_in & OPERAND_MASK;
		den = den_in & OPERAND_MASK;
		w.zero_divisor = 1'b0;
		if (den == '0) begin
			w.remainder    = '0;
			w.zero_divisor = 1'b1;
		end else if (is_unsigned) begin
			w.remainder = num % den;
		end else begin
			den_mag = abs_value(den);
			trunc   = abs_value(num) % den_mag;
			// negative dividend with a nonzero remainder folds up by |divisor|
			if (num[DATA_WIDTH-1] && trunc != '0)
				w.remainder = (den_mag - trunc) & OPERAND_MASK;
			else
				w.remainder = trunc;
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			errors  <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing outstanding: remainder %h",
						remainder);
					errors <= errors + 1;
				end else begin
					oldest = expected_words.pop_front();
					checked <= checked + 1;
					bad = 0;
					if (remainder !== oldest.remainder) begin
						$error("remainder: expected %h, got %h", oldest.remainder, remainder);
						bad++;
					end
					if (zero_divisor !== oldest.zero_divisor) begin
						$error("zero_divisor: expected %b, got %b",
							oldest.zero_divisor, zero_divisor);
						bad++;
					end
					errors <= errors + bad;
				end
			end
			if (start && !busy)
				expected_words.push_back(euclid_remainder(func, dividend, divisor));
			pending <= expected_words.size();
		end
	end

endmodule

FILE: bench/euclidean_modulo_int64_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_modulo_int64_test: testbench top for the Euclidean modulo unit
// Drives command words (directed corners, then shaped random operands) with
// random idle bursts, and lets the checker compare every result word.
// ----------------------------------------------------------------------------
module euclidean_modulo_int64_test;

	localparam int DATA_WIDTH = emi_pkg::DATA_WIDTH_DEF;

	// func codes
	localparam logic FUNC_SIGNED   = 1'b0;
	localparam logic FUNC_UNSIGNED = 1'b1;

	// operand corners
	localparam logic [63:0] SMIN      = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SMAX      = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;

	localparam int RANDOM_WORDS   = 1500;
	localparam int QUIET_TAIL     = 200;   // last words go back to back
	// pipeline is DATA_WIDTH + 2 deep; drain a bit past that
	localparam int DRAIN_CYCLES   = DATA_WIDTH + 2 + 16;
	// worst gap between accepts/results: the longest idle burst plus the pipe
	localparam int WATCHDOG_LIMIT = 2000;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic                        func;
	logic [emi_pkg::FIELD_W-1:0] dividend;
	logic [emi_pkg::FIELD_W-1:0] divisor;
	logic                        done;
	logic [emi_pkg::FIELD_W-1:0] remainder;
	logic                        zero_divisor;

	int errors;
	int pending;
	int checked;
	int idle_cycles;
	int sent_signed;
	int sent_unsigned;
	int sent_zero_div;

	euclidean_modulo_int64 #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.dividend     (dividend),
		.divisor      (divisor),
		.done         (done),
		.remainder    (remainder),
		.zero_divisor (zero_divisor)
	);

	euclidean_modulo_int64_check #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.dividend     (dividend),
		.divisor      (divisor),
		.done         (done),
		.remainder    (remainder),
		.zero_divisor (zero_divisor),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: anything accepted on either side resets the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles, %0d words outstanding",
					WATCHDOG_LIMIT, pending);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand_wide();
		return {$urandom, $urandom};
	endfunction

	// operand classes that hit the sign and magnitude corners often
	function automatic logic [63:0] pick_operand();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = rand_wide();
			2: begin
				v = 64'($urandom_range(0, 40));
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			3: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = 64'd1;
					2: v = ALL_ONES;
					3: v = SMIN;
					4: v = SMAX;
					default: v = SMIN + 1;
				endcase
			end
			default: begin
				// random magnitude, random sign
				v = rand_wide() >> $urandom_range(1, 63);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
		endcase
		return v;
	endfunction

	// hold the word on the ports until an edge sees busy low
	// busy is read at the falling edge, where it has settled for this cycle
	task automatic send_word(input logic f, input logic [63:0] a, input logic [63:0] b);
		logic taken;
		start    <= 1'b1;
		func     <= f;
		dividend <= a;
		divisor  <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		if (b == '0)
			sent_zero_div++;
		if (f == FUNC_UNSIGNED)
			sent_unsigned++;
		else
			sent_signed++;
	endtask

	// idle burst; payload is randomized so a dropped start is noticed
	task automatic idle_burst(input int cycles);
		start    <= 1'b0;
		func     <= 1'($urandom);
		dividend <= rand_wide();
		divisor  <= rand_wide();
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		logic [63:0] num;
		logic [63:0] den;
		logic        mode;
		sent_signed   = 0;
		sent_unsigned = 0;
		sent_zero_div = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		func     = FUNC_SIGNED;
		dividend = '0;
		divisor  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners: unsigned
		send_word(FUNC_UNSIGNED, 64'd0, 64'd1);
		send_word(FUNC_UNSIGNED, ALL_ONES, 64'd1);
		send_word(FUNC_UNSIGNED, ALL_ONES, ALL_ONES);
		send_word(FUNC_UNSIGNED, ALL_ONES, SMIN);
		send_word(FUNC_UNSIGNED, 64'd12345, 64'd0);
		send_word(FUNC_UNSIGNED, 64'd0, 64'd0);
		idle_burst(3);
		// directed corners: signed
		send_word(FUNC_SIGNED, SMIN, ALL_ONES);      // most negative over minus one
		send_word(FUNC_SIGNED, SMIN, SMIN);
		send_word(FUNC_SIGNED, -64'd7, 64'd2);
		send_word(FUNC_SIGNED, 64'd7, -64'd2);
		send_word(FUNC_SIGNED, -64'd7, -64'd2);
		send_word(FUNC_SIGNED, -64'd8, 64'd4);       // negative, exact multiple
		send_word(FUNC_SIGNED, ALL_ONES, SMIN);      // fold-up by 2^63
		send_word(FUNC_SIGNED, SMAX, SMIN);
		send_word(FUNC_SIGNED, SMIN, SMAX);
		send_word(FUNC_SIGNED, SMIN, 64'd0);
		send_word(FUNC_SIGNED, SMAX, 64'd1);
		send_word(FUNC_SIGNED, SMIN, 64'd3);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 7) == 0)
				idle_burst($urandom_range(1, 16));
			mode = 1'($urandom);
			den  = ($urandom_range(0, 31) == 0) ? 64'd0 : pick_operand();
			// some dividends are exact multiples so the zero-remainder path shows up
			if ($urandom_range(0, 7) == 0)
				num = den * 64'($urandom_range(0, 1000));
			else
				num = pick_operand();
			send_word(mode, num, den);
		end
		start <= 1'b0;

		// the watchdog bounds this wait
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words: %0d signed, %0d unsigned, %0d with a zero divisor",
			sent_signed + sent_unsigned, sent_signed, sent_unsigned, sent_zero_div);
		$display("compared %0d result words, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
